FILE: src/hsl_to_rgb_unit_defines.svh
// ----------------------------------------------------------------------------
// HSL to RGB unit assertion macros
// Shared concurrent assertion forms, clocked on i_clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HSL_TO_RGB_UNIT_DEFINES_SVH
`define HSL_TO_RGB_UNIT_DEFINES_SVH

// condition must never hold
`define HSL_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("hsl: forbidden condition seen");

// antecedent must be followed by the consequent in the next cycle
`define HSL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hsl: expected follow-up missing");

`endif

FILE: src/hsl_pkg.sv
// ----------------------------------------------------------------------------
// HSL to RGB package
// Item types, hue sextant constants and the classified item shared by the
// front end, the queue and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package hsl_pkg;

    localparam int unsigned X_W    = 19;
    localparam int unsigned FRAC_W = 17;
    localparam int unsigned CHANNELS = 3;

    localparam int unsigned CH_RED   = 0;
    localparam int unsigned CH_GREEN = 1;
    localparam int unsigned CH_BLUE  = 2;

    localparam logic [X_W-1:0] ONE_SEXT   = 19'd65536;
    localparam logic [X_W-1:0] THIRD_TURN = 19'd131072;
    localparam logic [X_W-1:0] HALF_TURN  = 19'd196608;
    localparam logic [X_W-1:0] TWO_THIRDS = 19'd262144;
    localparam logic [X_W-1:0] FULL_TURN  = 19'd393216;

    typedef struct packed {
        logic [15:0] hue;
        logic [15:0] saturation;
        logic [15:0] lightness;
    } t_hsl_item;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } t_rgb_item;

    typedef enum logic [1:0] {
        REG_RISE,
        REG_HIGH,
        REG_FALL,
        REG_LOW
    } t_region;

    typedef struct packed {
        t_region           region;
        logic [FRAC_W-1:0] frac;
    } t_chan;

    typedef struct packed {
        logic                       gray;
        logic [15:0]                sat;
        logic [15:0]                light;
        logic [31:0]                prod;
        t_chan [CHANNELS-1:0]       chan;
    } t_cls;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

`default_nettype wire

FILE: src/hsl_front.sv
// ----------------------------------------------------------------------------
// HSL front end
// Accepts items, forms lightness times saturation, offsets the hue per
// channel and sorts each channel into its ramp region.
// ----------------------------------------------------------------------------
`default_nettype none

module hsl_front (
    input  wire logic              i_valid,
    input  wire hsl_pkg::t_hsl_item i_item,
    input  wire hsl_pkg::t_q_status i_q_status,
    output logic                   o_stall,
    output logic                   o_push,
    output hsl_pkg::t_cls          o_cls
);

    function automatic hsl_pkg::t_chan classify(input logic [hsl_pkg::X_W-1:0] x);
        hsl_pkg::t_chan         c;
        logic [hsl_pkg::X_W-1:0] d;
        d        = hsl_pkg::TWO_THIRDS - x;
        c.region = hsl_pkg::REG_LOW;
        c.frac   = '0;
        if (x < hsl_pkg::ONE_SEXT) begin
            c.region = hsl_pkg::REG_RISE;
            c.frac   = {1'b0, x[15:0]};
        end else if (x < hsl_pkg::HALF_TURN) begin
            c.region = hsl_pkg::REG_HIGH;
        end else if (x < hsl_pkg::TWO_THIRDS) begin
            c.region = hsl_pkg::REG_FALL;
            c.frac   = d[hsl_pkg::FRAC_W-1:0];
        end
        return c;
    endfunction

    logic [hsl_pkg::X_W-1:0] xg;
    logic [hsl_pkg::X_W-1:0] xr_raw;
    logic [hsl_pkg::X_W-1:0] xr;
    logic [hsl_pkg::X_W-1:0] xb;

    assign o_stall = i_q_status.full;
    assign o_push  = i_valid && !i_q_status.full;

    assign xg     = {1'b0, i_item.hue, 2'b00} + {2'b00, i_item.hue, 1'b0};
    assign xr_raw = xg + hsl_pkg::THIRD_TURN;
    assign xr     = (xr_raw > hsl_pkg::FULL_TURN) ? xr_raw - hsl_pkg::FULL_TURN : xr_raw;
    assign xb     = (xg < hsl_pkg::THIRD_TURN)
                    ? xg + (hsl_pkg::FULL_TURN - hsl_pkg::THIRD_TURN)
                    : xg - hsl_pkg::THIRD_TURN;

    always_comb begin
        o_cls.gray  = (i_item.saturation == 16'd0);
        o_cls.sat   = i_item.saturation;
        o_cls.light = i_item.lightness;
        o_cls.prod  = {16'd0, i_item.lightness} * {16'd0, i_item.saturation};
        o_cls.chan[hsl_pkg::CH_RED]   = classify(xr);
        o_cls.chan[hsl_pkg::CH_GREEN] = classify(xg);
        o_cls.chan[hsl_pkg::CH_BLUE]  = classify(xb);
    end

endmodule

`default_nettype wire

FILE: src/hsl_queue.sv
// ----------------------------------------------------------------------------
// HSL classified item queue
// Short register queue between front and back ends; head read directly.
// ----------------------------------------------------------------------------
`default_nettype none

module hsl_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire hsl_pkg::t_cls i_data,
    input  wire logic          i_pop,
    output hsl_pkg::t_cls      o_data,
    output hsl_pkg::t_q_status o_status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    hsl_pkg::t_cls     r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_count;
    logic [PTR_W-1:0]  n_wr;
    logic [PTR_W-1:0]  n_rd;
    logic [CNT_W-1:0]  n_count;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_data         = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

FILE: src/hsl_back.sv
// ----------------------------------------------------------------------------
// HSL back end
// Four-stage pipeline: high level, low level and span, ramp products,
// then level selection, rounding, saturation and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hsl_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire hsl_pkg::t_cls      i_cls,
    input  wire hsl_pkg::t_q_status i_q_status,
    output logic                    o_pop,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output hsl_pkg::t_rgb_item      o_item
);

    localparam int unsigned NCH = hsl_pkg::CHANNELS;

    logic advance;

    logic r_vld1;
    logic r_vld2;
    logic r_vld3;
    logic r_out_vld;

    // stage 1
    logic                   r_gray1;
    logic [15:0]            r_light1;
    logic [31:0]            r_hi1;
    hsl_pkg::t_chan [NCH-1:0] r_chan1;
    // stage 2
    logic                   r_gray2;
    logic [15:0]            r_light2;
    logic [31:0]            r_hi2;
    logic [31:0]            r_lo2;
    logic [31:0]            r_span2;
    hsl_pkg::t_chan [NCH-1:0] r_chan2;
    // stage 3
    logic                   r_gray3;
    logic [15:0]            r_light3;
    logic [31:0]            r_hi3;
    logic [31:0]            r_lo3;
    logic [31:0]            r_slope3 [NCH];
    hsl_pkg::t_region       r_region3 [NCH];
    // output
    hsl_pkg::t_rgb_item     r_out;

    logic [32:0]            hi_wide;
    logic [32:0]            lo_wide;
    logic [32:0]            span_wide;
    logic [48:0]            ramp [NCH];
    logic [15:0]            level [NCH];
    hsl_pkg::t_rgb_item     n_out;

    assign advance = !r_out_vld || !i_stall;
    assign o_pop   = advance && !i_q_status.empty;
    assign o_valid = r_out_vld;
    assign o_item  = r_out;

    always_comb begin
        if (!i_cls.light[15]) begin
            hi_wide = {1'b0, i_cls.light, 16'd0} + {1'b0, i_cls.prod};
        end else begin
            hi_wide = {({1'b0, i_cls.light} + {1'b0, i_cls.sat}), 16'd0}
                      - {1'b0, i_cls.prod};
        end
    end

    assign lo_wide   = {r_light1, 17'd0} - {1'b0, r_hi1};
    assign span_wide = {r_hi1, 1'b0} - {r_light1, 17'd0};

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            ramp[c] = {17'd0, r_span2} * {32'd0, r_chan2[c].frac};
        end
    end

    always_comb begin
        logic [31:0] v;
        logic [32:0] rnd;
        for (int c = 0; c < NCH; c++) begin
            unique case (r_region3[c]) inside
                hsl_pkg::REG_RISE,
                hsl_pkg::REG_FALL: v = r_lo3 + r_slope3[c];
                hsl_pkg::REG_HIGH: v = r_hi3;
                hsl_pkg::REG_LOW:  v = r_lo3;
                default:           v = r_lo3;
            endcase
            rnd = {1'b0, v} + 33'd32768;
            if (r_gray3) begin
                level[c] = r_light3;
            end else if (rnd[32]) begin
                level[c] = 16'hFFFF;
            end else begin
                level[c] = rnd[31:16];
            end
        end
        n_out.red   = level[hsl_pkg::CH_RED];
        n_out.green = level[hsl_pkg::CH_GREEN];
        n_out.blue  = level[hsl_pkg::CH_BLUE];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1    <= 1'b0;
            r_vld2    <= 1'b0;
            r_vld3    <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_vld1    <= !i_q_status.empty;
            r_vld2    <= r_vld1;
            r_vld3    <= r_vld2;
            r_out_vld <= r_vld3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_gray1  <= i_cls.gray;
            r_light1 <= i_cls.light;
            r_hi1    <= hi_wide[31:0];
            r_chan1  <= i_cls.chan;

            r_gray2  <= r_gray1;
            r_light2 <= r_light1;
            r_hi2    <= r_hi1;
            r_lo2    <= lo_wide[31:0];
            r_span2  <= span_wide[31:0];
            r_chan2  <= r_chan1;

            r_gray3  <= r_gray2;
            r_light3 <= r_light2;
            r_hi3    <= r_hi2;
            r_lo3    <= r_lo2;
            for (int c = 0; c < NCH; c++) begin
                r_slope3[c]  <= ramp[c][47:16];
                r_region3[c] <= r_chan2[c].region;
            end

            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

FILE: src/hsl_to_rgb_unit.sv
// ----------------------------------------------------------------------------
// HSL to RGB unit
// Throughput: one item per cycle while i_stall is low; the back end is a four-stage pipeline.
// An accepted item is written to the queue, then registered through back-end stages
// 1 to 3 and the output register before o_valid; an output stall holds every stage.
// The queue holds QUEUE_DEPTH classified items; o_stall rises when it is full.
// Reset clears the queue and pipeline valids; the data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "hsl_to_rgb_unit_defines.svh"

module hsl_to_rgb_unit #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire hsl_pkg::t_hsl_item i_hsl,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output hsl_pkg::t_rgb_item      o_rgb
);

    logic               push;
    logic               pop;
    hsl_pkg::t_cls      front_cls;
    hsl_pkg::t_cls      head_cls;
    hsl_pkg::t_q_status q_status;
    logic               in_fire;
    logic               out_free;

    assign in_fire  = i_valid && !o_stall;
    assign out_free = !o_valid || !i_stall;

    hsl_front u_front (
        .i_valid    (i_valid),
        .i_item     (i_hsl),
        .i_q_status (q_status),
        .o_stall    (o_stall),
        .o_push     (push),
        .o_cls      (front_cls)
    );

    hsl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (front_cls),
        .i_pop    (pop),
        .o_data   (head_cls),
        .o_status (q_status)
    );

    hsl_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cls      (head_cls),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_item     (o_rgb)
    );

    `HSL_ASSERT_NEVER(a_queue_full_and_empty, q_status.full && q_status.empty)
    `HSL_ASSERT_NEXT(a_accept_fills_queue, in_fire, !q_status.empty)
    `HSL_ASSERT_NEXT(a_pipeline_latency, (in_fire && q_status.empty) ##1 out_free[*4], o_valid)

endmodule

`default_nettype wire

FILE: tb/tb_hsl_to_rgb_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HSL to RGB unit testbench
// Streams HSL colours through the unit and compares every RGB item with a typed
// row's table value or an independent fixed-point model of the conversion: a
// directed table of grey, black, full-scale and sextant-edge colours, then randomised
// bursts with random gaps while the output side stalls in changing patterns.
// ----------------------------------------------------------------------------

module tb_hsl_to_rgb_unit;

    localparam int RANDOM_ITEMS   = 1700;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_ROWS         = 23;

    typedef struct packed {
        hsl_pkg::t_hsl_item hsl;
        logic               typed;
        hsl_pkg::t_rgb_item rgb;
    } t_dir_row;

    typedef struct packed {
        hsl_pkg::t_hsl_item src;
        hsl_pkg::t_rgb_item rgb;
    } t_rgb_entry;

    // hue, saturation, lightness, typed, red, green, blue
    localparam t_dir_row DIR_ROWS [0:N_ROWS-1] = '{
        {16'd0,     16'd0,     16'd0,     1'b1, 16'd0,     16'd0,     16'd0},
        {16'd65535, 16'd0,     16'd65535, 1'b1, 16'd65535, 16'd65535, 16'd65535},
        {16'd12345, 16'd0,     16'd40000, 1'b1, 16'd40000, 16'd40000, 16'd40000},
        {16'd0,     16'd65535, 16'd0,     1'b1, 16'd0,     16'd0,     16'd0},
        {16'd65535, 16'd65535, 16'd0,     1'b1, 16'd0,     16'd0,     16'd0},
        {16'd0,     16'd65535, 16'd32768, 1'b0, 48'd0},
        {16'd10922, 16'd65535, 16'd32768, 1'b0, 48'd0},
        {16'd10923, 16'd65535, 16'd32768, 1'b0, 48'd0},
        {16'd21845, 16'd65535, 16'd32768, 1'b0, 48'd0},
        {16'd21846, 16'd65535, 16'd32768, 1'b0, 48'd0},
        {16'd32768, 16'd65535, 16'd32768, 1'b0, 48'd0},
        {16'd43690, 16'd65535, 16'd32768, 1'b0, 48'd0},
        {16'd43691, 16'd65535, 16'd32768, 1'b0, 48'd0},
        {16'd65535, 16'd65535, 16'd32768, 1'b0, 48'd0},
        {16'd0,     16'd65535, 16'd65535, 1'b0, 48'd0},
        {16'd21845, 16'd65535, 16'd65535, 1'b0, 48'd0},
        {16'd5000,  16'd1,     16'd32767, 1'b0, 48'd0},
        {16'd30000, 16'd65535, 16'd32767, 1'b0, 48'd0},
        {16'd50000, 16'd32768, 16'd16384, 1'b0, 48'd0},
        {16'd60000, 16'd40000, 16'd50000, 1'b0, 48'd0},
        {16'd1,     16'd65535, 16'd32768, 1'b0, 48'd0},
        {16'hAAAA,  16'h5555,  16'hAAAA,  1'b0, 48'd0},
        {16'h5555,  16'hAAAA,  16'h5555,  1'b0, 48'd0}
    };

    localparam logic [15:0] HUE_EDGES [0:11] = '{
        16'd0, 16'd10922, 16'd10923, 16'd21845, 16'd21846, 16'd32767,
        16'd32768, 16'd43690, 16'd43691, 16'd54613, 16'd54614, 16'd65535
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               i_stall = 1'b0;
    hsl_pkg::t_hsl_item i_hsl = '0;
    logic               o_stall;
    logic               o_valid;
    hsl_pkg::t_rgb_item o_rgb;

    logic               row_typed = 1'b0;
    hsl_pkg::t_rgb_item row_rgb = '0;

    t_rgb_entry pending_rgb [$];
    t_rgb_entry head;
    int         error_count = 0;
    int         checked_count = 0;
    int         grey_count = 0;
    int         accepted_count = 0;
    int         idle_cycles = 0;
    int         stall_cycles = 0;
    int         stall_mode = 0;

    hsl_to_rgb_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_hsl   (i_hsl),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rgb   (o_rgb)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [63:0] ramp_level(logic [31:0] x, logic [63:0] lo,
                                               logic [63:0] hi);
        logic [63:0] span;
        span = hi - lo;
        if (x < 32'(hsl_pkg::ONE_SEXT)) begin
            return lo + ((span * 64'(x)) >> 16);
        end else if (x < 32'(hsl_pkg::HALF_TURN)) begin
            return hi;
        end else if (x < 32'(hsl_pkg::TWO_THIRDS)) begin
            return lo + ((span * 64'(32'(hsl_pkg::TWO_THIRDS) - x)) >> 16);
        end
        return lo;
    endfunction

    function automatic logic [15:0] round_sat(logic [63:0] v);
        logic [63:0] r;
        r = (v + 64'd32768) >> 16;
        return (r > 64'd65535) ? 16'hFFFF : r[15:0];
    endfunction

    function automatic hsl_pkg::t_rgb_item rgb_from_hsl(hsl_pkg::t_hsl_item p);
        logic [63:0]        s, l, hi, lo;
        logic [31:0]        xg, xr, xb;
        hsl_pkg::t_rgb_item c;
        s = 64'(p.saturation);
        l = 64'(p.lightness);
        if (s == 0) begin
            c.red   = p.lightness;
            c.green = p.lightness;
            c.blue  = p.lightness;
            return c;
        end
        if (l < 64'd32768) begin
            hi = l * (64'd65536 + s);
        end else begin
            hi = ((l + s) << 16) - l * s;
        end
        lo = (l << 17) - hi;
        xg = 32'(p.hue) * 32'd6;
        xr = xg + 32'(hsl_pkg::THIRD_TURN);
        if (xr > 32'(hsl_pkg::FULL_TURN)) begin
            xr = xr - 32'(hsl_pkg::FULL_TURN);
        end
        if (xg < 32'(hsl_pkg::THIRD_TURN)) begin
            xb = xg + 32'(hsl_pkg::FULL_TURN) - 32'(hsl_pkg::THIRD_TURN);
        end else begin
            xb = xg - 32'(hsl_pkg::THIRD_TURN);
        end
        c.red   = round_sat(ramp_level(xr, lo, hi));
        c.green = round_sat(ramp_level(xg, lo, hi));
        c.blue  = round_sat(ramp_level(xb, lo, hi));
        return c;
    endfunction

    // check results first, then log the new item, so a result never meets its own item
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                checked_count++;
                if (pending_rgb.size() == 0) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("unexpected item: got %h %h %h",
                                 o_rgb.red, o_rgb.green, o_rgb.blue);
                    end
                end else begin
                    head = pending_rgb.pop_front();
                    if (o_rgb.red !== head.rgb.red || o_rgb.green !== head.rgb.green ||
                        o_rgb.blue !== head.rgb.blue) begin
                        error_count++;
                        if (error_count <= 10) begin
                            $display("mismatch for hsl %h %h %h: want %h %h %h got %h %h %h",
                                     head.src.hue, head.src.saturation, head.src.lightness,
                                     head.rgb.red, head.rgb.green, head.rgb.blue,
                                     o_rgb.red, o_rgb.green, o_rgb.blue);
                        end
                    end
                end
            end
            if (i_valid && !o_stall) begin
                accepted_count++;
                if (i_hsl.saturation == 16'd0) begin
                    grey_count++;
                end
                pending_rgb.push_back({i_hsl, row_typed ? row_rgb : rgb_from_hsl(i_hsl)});
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", idle_cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        stall_cycles <= stall_cycles + 1;
        if (stall_cycles % 256 == 0) begin
            stall_mode <= $urandom_range(0, 3);
        end
        case (stall_mode)
            0: begin
                i_stall <= 1'b0;
            end
            1: begin
                i_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
                i_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                i_stall <= (stall_cycles % 3 == 0);
            end
        endcase
    end

    task automatic offer(input hsl_pkg::t_hsl_item hsl, input logic typed,
                         input hsl_pkg::t_rgb_item rgb);
        @(negedge i_clk);
        i_valid   <= 1'b1;
        i_hsl     <= hsl;
        row_typed <= typed;
        row_rgb   <= rgb;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic hold_off(input int cycles);
        @(negedge i_clk);
        i_valid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic drain;
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_rgb.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        hsl_pkg::t_hsl_item pick;
        int                 sent;
        int                 burst;
        int                 gap;
        int                 r;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < N_ROWS; k++) begin
            offer(DIR_ROWS[k].hsl, DIR_ROWS[k].typed, DIR_ROWS[k].rgb);
            if ($urandom_range(0, 3) == 0) begin
                hold_off($urandom_range(1, 4));
            end
        end
        drain();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 24);
            for (int j = 0; j < burst && sent < RANDOM_ITEMS; j++) begin
                if ($urandom_range(0, 9) < 3) begin
                    pick.hue = HUE_EDGES[$urandom_range(0, 11)];
                end else begin
                    pick.hue = 16'($urandom_range(0, 65535));
                end
                r = $urandom_range(0, 19);
                case (r) inside
                    0, 1: pick.saturation = 16'd0;
                    2: pick.saturation = 16'd65535;
                    3: pick.saturation = 16'd1;
                    default: pick.saturation = 16'($urandom_range(0, 65535));
                endcase
                r = $urandom_range(0, 19);
                case (r)
                    0: pick.lightness = 16'd0;
                    1: pick.lightness = 16'd65535;
                    2: pick.lightness = 16'd32767;
                    3: pick.lightness = 16'd32768;
                    default: pick.lightness = 16'($urandom_range(0, 65535));
                endcase
                offer(pick, 1'b0, '0);
                sent++;
                if (sent == RANDOM_ITEMS / 2) begin
                    drain();
                end
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                hold_off(gap);
            end
        end

        drain();
        repeat (16) @(negedge i_clk);

        $display("converted %0d colours (%0d from the directed table, %0d grey)",
                 accepted_count, N_ROWS, grey_count);
        $display("compared %0d RGB items under bursty input and varying output stalls",
                 checked_count);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
